@@ hdl/fbcm_pkg.sv @@
// Package for the Feistel block cipher with chaining modes.
// Holds register indexes, mode codes, reset values and the round functions.
// No dependencies.
package fbcm_pkg;

    localparam int ROUND_COUNT_DEF = 8;

    localparam int BLOCK_W = 64;
    localparam int HALF_W  = 32;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_ECB = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CBC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFB = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_KEY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VEC   = 2'd3;

    localparam logic [BLOCK_W-1:0] KEY_RESET = 64'hF0B1_AAF0_B1AB_ABAB;
    localparam logic [BLOCK_W-1:0] IV_RESET  = 64'h0198_4AA4_51CB_ACAB;

    typedef struct packed {
        logic [MODE_W-1:0]  chain_mode;
        logic               decrypt_select;
        logic [BLOCK_W-1:0] base_key;
        logic [BLOCK_W-1:0] init_vector;
    } t_cfg;

    // low word of the key rotated right by whole bytes
    function automatic logic [HALF_W-1:0] f_round_key(input logic [BLOCK_W-1:0] key,
                                                      input int unsigned idx);
        logic [2*BLOCK_W-1:0] dbl;
        dbl = {key, key} >> (8 * (idx % 8));
        return dbl[HALF_W-1:0];
    endfunction

    // F(x,k) = rotr(x,7) ^ (rotl(k,9) | x)
    function automatic logic [HALF_W-1:0] f_round(input logic [HALF_W-1:0] x,
                                                  input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] xr;
        logic [HALF_W-1:0] kl;
        xr = {x[6:0], x[HALF_W-1:7]};
        kl = {k[HALF_W-10:0], k[HALF_W-1:HALF_W-9]};
        return xr ^ (kl | x);
    endfunction

endpackage

@@ hdl/fbcm_cfg_regs.sv @@
// Configuration register file: chain mode, decrypt select, base key, IV.
// Depends on fbcm_pkg.
module fbcm_cfg_regs
    import fbcm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BLOCK_W-1:0]   i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chain_mode     <= MODE_ECB;
            r_cfg.decrypt_select <= 1'b0;
            r_cfg.base_key       <= KEY_RESET;
            r_cfg.init_vector    <= IV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHAIN_MODE: r_cfg.chain_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_DECRYPT:    r_cfg.decrypt_select <= i_cfg_data[0];
                CFG_BASE_KEY:   r_cfg.base_key       <= i_cfg_data;
                CFG_INIT_VEC:   r_cfg.init_vector    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/fbcm_feistel.sv @@
// Combinational Feistel network, one round per generate stage.
// Depends on fbcm_pkg.
module fbcm_feistel
    import fbcm_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic [BLOCK_W-1:0] i_block,
    input  logic [BLOCK_W-1:0] i_base_key,
    input  logic               i_reverse,
    output logic [BLOCK_W-1:0] o_block
);

    logic [HALF_W-1:0] w_lo [0:ROUND_COUNT-1];
    logic [HALF_W-1:0] w_hi [0:ROUND_COUNT-1];
    logic [HALF_W-1:0] w_last_key;

    assign w_lo[0] = i_block[HALF_W-1:0];
    assign w_hi[0] = i_block[BLOCK_W-1:HALF_W];

    for (genvar r = 0; r < ROUND_COUNT - 1; r++) begin : g_round
        localparam int unsigned KF = r;
        localparam int unsigned KR = ROUND_COUNT - 1 - r;
        logic [HALF_W-1:0] w_key;
        assign w_key = i_reverse ? f_round_key(i_base_key, KR) : f_round_key(i_base_key, KF);
        assign w_lo[r+1] = w_hi[r] ^ f_round(w_lo[r], w_key);
        assign w_hi[r+1] = w_lo[r];
    end

    // last round keeps the halves in place
    assign w_last_key = i_reverse ? f_round_key(i_base_key, 0)
                                  : f_round_key(i_base_key, ROUND_COUNT - 1);
    assign o_block = {w_hi[ROUND_COUNT-1] ^ f_round(w_lo[ROUND_COUNT-1], w_last_key),
                      w_lo[ROUND_COUNT-1]};

endmodule

@@ hdl/feistel_block_cipher_modes.sv @@
// Feistel block cipher, ECB / CBC / OFB, one block per cycle while the output is not stalled.
// Datapath: the input transaction is captured in the input register, then cipher logic
// feeds the result register. Throughput: 1 block per cycle while i_out_stall is low.
// Chaining feedback completes within the single cipher pass.
// Synchronous active-low reset: pipeline empty, chain value zero, registers at defaults.
// Depends on fbcm_pkg, fbcm_cfg_regs, fbcm_feistel.
module feistel_block_cipher_modes
    import fbcm_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BLOCK_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BLOCK_W-1:0]   i_data_block,
    input  logic                 i_start_of_message,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BLOCK_W-1:0]   o_result_block
);

    t_cfg               w_cfg;
    logic               r_in_valid;
    logic [BLOCK_W-1:0] r_in_data;
    logic               r_in_som;
    logic               r_out_valid;
    logic [BLOCK_W-1:0] r_out_data;
    logic [BLOCK_W-1:0] r_chain;
    logic [BLOCK_W-1:0] n_chain;
    logic [BLOCK_W-1:0] n_result;
    logic [BLOCK_W-1:0] w_chain_cur;
    logic [BLOCK_W-1:0] w_core_in;
    logic [BLOCK_W-1:0] w_core_out;
    logic               w_reverse;
    logic               w_advance;
    logic               w_in_take;

    fbcm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    fbcm_feistel #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_feistel (
        .i_block    (w_core_in),
        .i_base_key (w_cfg.base_key),
        .i_reverse  (w_reverse),
        .o_block    (w_core_out)
    );

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign w_chain_cur = r_in_som ? w_cfg.init_vector : r_chain;

    always_comb begin
        unique case (w_cfg.chain_mode)
            MODE_CBC: begin
                w_reverse = w_cfg.decrypt_select;
                if (w_cfg.decrypt_select) begin
                    w_core_in = r_in_data;
                    n_result  = w_core_out ^ w_chain_cur;
                    n_chain   = r_in_data;
                end else begin
                    w_core_in = r_in_data ^ w_chain_cur;
                    n_result  = w_core_out;
                    n_chain   = w_core_out;
                end
            end
            MODE_OFB: begin
                w_reverse = 1'b0;
                w_core_in = w_chain_cur;
                n_result  = w_core_out ^ r_in_data;
                n_chain   = w_core_out;
            end
            default: begin
                w_reverse = w_cfg.decrypt_select;
                w_core_in = r_in_data;
                n_result  = w_core_out;
                n_chain   = w_chain_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_advance && r_in_valid) begin
                r_chain <= n_chain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_data <= i_data_block;
            r_in_som  <= i_start_of_message;
        end
        if (w_advance && r_in_valid) begin
            r_out_data <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_block = r_out_data;

endmodule

@@ hdl/fbcm_checker.sv @@
// Port-level checks for the Feistel cipher top level, bound to it below.
// Depends on fbcm_pkg and feistel_block_cipher_modes.
module fbcm_checker
    import fbcm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [BLOCK_W-1:0]   o_result_block
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while result register empty");

    a_stall_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_block)))
        else $error("stalled result dropped or changed");

endmodule

bind feistel_block_cipher_modes fbcm_checker u_fbcm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_block (o_result_block)
);

@@ test/tb_top.sv @@
// Self-checking testbench for feistel_block_cipher_modes (ECB, CBC and OFB over an 8-round
// Feistel cipher): a directed table, then random traffic checked by a built-in predictor.
// Depends on fbcm_pkg and the feistel_block_cipher_modes RTL.
`timescale 1ns / 100ps

module tb_top;
    import fbcm_pkg::*;

    localparam int ROUNDS = ROUND_COUNT_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 650;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [BLOCK_W-1:0] ZERO = '0;
    localparam logic [BLOCK_W-1:0] ONES = '1;
    localparam logic [BLOCK_W-1:0] PAT_A = 64'h0123_4567_89AB_CDEF;
    localparam logic [BLOCK_W-1:0] PAT_B = 64'hDEAD_BEEF_5A5A_A5A5;
    localparam logic [BLOCK_W-1:0] MSB_LSB = 64'h8000_0000_0000_0001;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic               dec;
        logic [BLOCK_W-1:0] key;
        logic [BLOCK_W-1:0] iv;
        logic [BLOCK_W-1:0] data;
        logic               som;
        logic               fixed;
        logic [BLOCK_W-1:0] want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_CHAIN_MODE;
    logic [BLOCK_W-1:0]   i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BLOCK_W-1:0]   i_data_block = '0;
    logic                 i_start_of_message = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [BLOCK_W-1:0]   o_result_block;

    logic                 drv_fixed = 1'b0;
    logic [BLOCK_W-1:0]   drv_want = '0;

    logic [MODE_W-1:0]    cfg_mode = MODE_ECB;
    logic                 cfg_dec = 1'b0;
    logic [BLOCK_W-1:0]   cfg_key = KEY_RESET;
    logic [BLOCK_W-1:0]   cfg_iv = IV_RESET;
    logic [BLOCK_W-1:0]   chain_reg = '0;

    logic [BLOCK_W-1:0]   result_q[$];
    int                   errors = 0;
    int                   quiet = 0;
    int                   tx_pct = 0;
    int                   rx_pct = 0;
    t_row                 plan[24];

    feistel_block_cipher_modes #(.ROUND_COUNT(ROUNDS)) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_block       (i_data_block),
        .i_start_of_message (i_start_of_message),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_block     (o_result_block)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [HALF_W-1:0] mix_half(input logic [HALF_W-1:0] x,
                                                   input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] xr;
        logic [HALF_W-1:0] kl;
        xr = (x >> 7) | (x << (HALF_W - 7));
        kl = (k << 9) | (k >> (HALF_W - 9));
        return xr ^ (kl | x);
    endfunction

    function automatic logic [HALF_W-1:0] sub_key(input logic [BLOCK_W-1:0] key, input int idx);
        logic [BLOCK_W-1:0] k;
        k = key;
        repeat (idx) k = {k[7:0], k[BLOCK_W-1:8]};
        return k[HALF_W-1:0];
    endfunction

    function automatic logic [BLOCK_W-1:0] feistel_pass(input logic [BLOCK_W-1:0] blk,
                                                        input logic [BLOCK_W-1:0] key,
                                                        input logic inv);
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] t;
        int r;
        lo = blk[HALF_W-1:0];
        hi = blk[BLOCK_W-1:HALF_W];
        for (r = 0; r < ROUNDS - 1; r++) begin
            t = hi ^ mix_half(lo, sub_key(key, inv ? ROUNDS - 1 - r : r));
            hi = lo;
            lo = t;
        end
        hi ^= mix_half(lo, sub_key(key, inv ? 0 : ROUNDS - 1));
        return {hi, lo};
    endfunction

    function automatic logic [BLOCK_W-1:0] cipher_step(input logic [BLOCK_W-1:0] d,
                                                       input logic som);
        logic [BLOCK_W-1:0] res;
        if (som) chain_reg = cfg_iv;
        case (cfg_mode)
            MODE_CBC: begin
                if (cfg_dec) begin
                    res = feistel_pass(d, cfg_key, 1'b1) ^ chain_reg;
                    chain_reg = d;
                end else begin
                    res = feistel_pass(d ^ chain_reg, cfg_key, 1'b0);
                    chain_reg = res;
                end
            end
            MODE_OFB: begin
                chain_reg = feistel_pass(chain_reg, cfg_key, 1'b0);
                res = chain_reg ^ d;
            end
            default: res = feistel_pass(d, cfg_key, cfg_dec);
        endcase
        return res;
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_wide();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return ZERO;
        if (sel == 1) return ONES;
        return {$urandom, $urandom};
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_pct);
    end

    always @(posedge i_clk) begin
        logic [BLOCK_W-1:0] want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CHAIN_MODE: cfg_mode = i_cfg_data[MODE_W-1:0];
                    CFG_DECRYPT:    cfg_dec = i_cfg_data[0];
                    CFG_BASE_KEY:   cfg_key = i_cfg_data;
                    CFG_INIT_VEC:   cfg_iv = i_cfg_data;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                want = cipher_step(i_data_block, i_start_of_message);
                if (drv_fixed) want = drv_want;
                result_q.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result_block: no transaction pending, actual %h", o_result_block);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (o_result_block !== want) begin
                        $error("result_block: expected %h, actual %h", want, o_result_block);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BLOCK_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [MODE_W-1:0] mode, input logic dec,
                              input logic [BLOCK_W-1:0] key, input logic [BLOCK_W-1:0] iv);
        logic [BLOCK_W-1:0] junk_mode;
        logic [BLOCK_W-1:0] junk_dec;
        drain();
        junk_mode = pick_wide();
        junk_dec = pick_wide();
        write_reg(CFG_CHAIN_MODE, {junk_mode[BLOCK_W-1:MODE_W], mode});
        write_reg(CFG_DECRYPT, {junk_dec[BLOCK_W-1:1], dec});
        write_reg(CFG_BASE_KEY, key);
        write_reg(CFG_INIT_VEC, iv);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_block(input logic [BLOCK_W-1:0] data, input logic som,
                              input logic fixed, input logic [BLOCK_W-1:0] want);
        while ($urandom_range(99) < tx_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_block <= data;
        i_start_of_message <= som;
        drv_fixed <= fixed;
        drv_want <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic random_phase(input int tx, input int rx);
        int sent;
        int seg;
        int sel;
        logic [MODE_W-1:0] mode;
        tx_pct = tx;
        rx_pct = rx;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            sel = $urandom_range(9);
            mode = (sel < 3) ? MODE_ECB : (sel < 6) ? MODE_CBC : (sel < 9) ? MODE_OFB : MODE_SPARE;
            set_config(mode, 1'($urandom_range(1)), pick_wide(), pick_wide());
            seg = $urandom_range(60, 10);
            for (int n = 0; n < seg; n++) begin
                if ($urandom_range(99) == 0) drain();
                send_block(pick_wide(),
                           (n == 0) ? ($urandom_range(99) < 80) : ($urandom_range(99) < 4),
                           1'b0, ZERO);
            end
            sent += seg;
        end
    endtask

    initial begin
        plan[0]  = '{MODE_CBC,   1'b0, KEY_RESET, IV_RESET, PAT_A,   1'b0, 1'b0, ZERO};
        plan[1]  = '{MODE_CBC,   1'b0, KEY_RESET, IV_RESET, PAT_A,   1'b0, 1'b0, ZERO};
        plan[2]  = '{MODE_ECB,   1'b0, KEY_RESET, IV_RESET, ZERO,    1'b0, 1'b0, ZERO};
        plan[3]  = '{MODE_ECB,   1'b0, KEY_RESET, IV_RESET, ONES,    1'b0, 1'b0, ZERO};
        plan[4]  = '{MODE_ECB,   1'b1, KEY_RESET, IV_RESET, ZERO,    1'b0, 1'b0, ZERO};
        plan[5]  = '{MODE_ECB,   1'b1, KEY_RESET, IV_RESET, ONES,    1'b1, 1'b0, ZERO};
        plan[6]  = '{MODE_SPARE, 1'b0, KEY_RESET, IV_RESET, PAT_A,   1'b0, 1'b0, ZERO};
        plan[7]  = '{MODE_SPARE, 1'b1, KEY_RESET, IV_RESET, PAT_A,   1'b1, 1'b0, ZERO};
        plan[8]  = '{MODE_CBC,   1'b0, KEY_RESET, IV_RESET, PAT_A,   1'b1, 1'b0, ZERO};
        plan[9]  = '{MODE_CBC,   1'b0, KEY_RESET, IV_RESET, PAT_B,   1'b0, 1'b0, ZERO};
        plan[10] = '{MODE_CBC,   1'b0, KEY_RESET, IV_RESET, ZERO,    1'b0, 1'b0, ZERO};
        plan[11] = '{MODE_CBC,   1'b1, KEY_RESET, IV_RESET, PAT_A,   1'b1, 1'b0, ZERO};
        plan[12] = '{MODE_CBC,   1'b1, KEY_RESET, IV_RESET, PAT_B,   1'b0, 1'b0, ZERO};
        plan[13] = '{MODE_OFB,   1'b0, KEY_RESET, IV_RESET, ZERO,    1'b1, 1'b0, ZERO};
        plan[14] = '{MODE_OFB,   1'b0, KEY_RESET, IV_RESET, ONES,    1'b0, 1'b0, ZERO};
        plan[15] = '{MODE_OFB,   1'b1, KEY_RESET, IV_RESET, PAT_B,   1'b0, 1'b0, ZERO};
        plan[16] = '{MODE_ECB,   1'b0, ZERO,      ZERO,     ZERO,    1'b0, 1'b1, ZERO};
        plan[17] = '{MODE_ECB,   1'b1, ZERO,      ZERO,     ZERO,    1'b0, 1'b1, ZERO};
        plan[18] = '{MODE_OFB,   1'b0, ZERO,      ZERO,     PAT_B,   1'b1, 1'b1, PAT_B};
        plan[19] = '{MODE_OFB,   1'b0, ZERO,      ZERO,     ONES,    1'b0, 1'b1, ONES};
        plan[20] = '{MODE_ECB,   1'b0, ONES,      ONES,     ZERO,    1'b0, 1'b0, ZERO};
        plan[21] = '{MODE_CBC,   1'b0, ONES,      ONES,     ONES,    1'b1, 1'b0, ZERO};
        plan[22] = '{MODE_CBC,   1'b1, ONES,      ONES,     ONES,    1'b1, 1'b0, ZERO};
        plan[23] = '{MODE_ECB,   1'b0, KEY_RESET, IV_RESET, MSB_LSB, 1'b0, 1'b0, ZERO};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_pct = 15;
        rx_pct = 47;
        for (int i = 0; i < 24; i++) begin
            if (i == 0 || plan[i].mode != plan[i-1].mode || plan[i].dec != plan[i-1].dec ||
                plan[i].key != plan[i-1].key || plan[i].iv != plan[i-1].iv) begin
                set_config(plan[i].mode, plan[i].dec, plan[i].key, plan[i].iv);
            end
            send_block(plan[i].data, plan[i].som, plan[i].fixed, plan[i].want);
        end

        random_phase(15, 47);
        random_phase(47, 15);
        random_phase(0, 0);

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
